// File: design/date_add_days_assert.svh
// Assertion macros shared by the date adder RTL.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define DAD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date adder check failed");

// Antecedent holds in this cycle, consequent in the next cycle.
`define DAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date adder check failed");

`endif

// File: design/dad_pkg.sv
// Shared types, widths, status codes and calendar tables for the date adder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dad_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int OFF_W   = 16;
  localparam int STAT_W  = 3;
  // Walked year may run past the top of the field before saturation.
  localparam int WYEAR_W = YEAR_W + 1;
  // Operand width of the shared unit: covers day plus offset and a full year.
  localparam int OPW     = 18;
  // Year modulo 400 needs nine bits.
  localparam int Y400_W  = 9;

  localparam int unsigned MIN_YEAR_DEF = 1900;

  localparam logic [WYEAR_W-1:0] YEAR_MAX   = WYEAR_W'(16383);
  localparam logic [OPW-1:0]     LEAP_CYCLE = OPW'(400);
  localparam logic [Y400_W-1:0]  Y400_LAST  = Y400_W'(399);
  localparam logic [Y400_W-1:0]  CENT_1     = Y400_W'(100);
  localparam logic [Y400_W-1:0]  CENT_2     = Y400_W'(200);
  localparam logic [Y400_W-1:0]  CENT_3     = Y400_W'(300);

  localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

  localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_LOW_YEAR  = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_BAD_MONTH = STAT_W'(2);
  localparam logic [STAT_W-1:0] ST_BAD_DAY   = STAT_W'(3);
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = STAT_W'(4);

  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    DAY_W'(0),  DAY_W'(31), DAY_W'(28), DAY_W'(31),
    DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31),
    DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
    DAY_W'(31), DAY_W'(0),  DAY_W'(0),  DAY_W'(0)
  };

  typedef struct packed {
    logic signed [OFF_W-1:0] days_away;
    logic [YEAR_W-1:0]       start_year;
    logic [DAY_W-1:0]        start_day;
    logic [MONTH_W-1:0]      start_month;
  } dad_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [YEAR_W-1:0]  result_year;
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
  } dad_result_t;

  typedef struct packed {
    logic signed [OPW-1:0] diff;
    logic                  pos;
    logic                  neg;
  } dad_alu_res_t;

  // Leap test on the year modulo 400: divisible by four, but not a bare century.
  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic div4;
    div4 = (y400[1:0] == 2'b00);
    return div4 && (y400 != CENT_1) && (y400 != CENT_2) && (y400 != CENT_3);
  endfunction

  function automatic logic [DAY_W-1:0] days_of(input logic [MONTH_W-1:0] m,
                                              input logic [Y400_W-1:0] y400);
    logic [DAY_W-1:0] n;
    n = MONTH_LEN[m];
    if (m == FEBRUARY && is_leap(y400)) begin
      n = DAY_W'(29);
    end
    return n;
  endfunction

endpackage

// File: design/dad_alu.sv
// Shared add/subtract and sign-compare unit of the date adder.
// Depends on dad_pkg for the operand width and result struct.
`timescale 1ns / 1ps

module dad_alu (
  input  logic signed [dad_pkg::OPW-1:0] a,
  input  logic signed [dad_pkg::OPW-1:0] b,
  input  logic                           sub,
  output dad_pkg::dad_alu_res_t          res
);
  import dad_pkg::*;

  logic signed [OPW-1:0] sum;

  assign sum      = sub ? (a - b) : (a + b);
  assign res.diff = sum;
  assign res.neg  = sum[OPW-1];
  assign res.pos  = !sum[OPW-1] && (sum != '0);

endmodule

// File: design/dad_ctrl.sv
// Sequencer and working registers of the date adder: offset add, year modulo 400
// by repeated subtraction, then the month walk. Depends on dad_pkg, dad_alu and date_add_days_assert.svh.
`timescale 1ns / 1ps
`include "date_add_days_assert.svh"

module dad_ctrl #(
  parameter int unsigned MIN_YEAR = dad_pkg::MIN_YEAR_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dad_pkg::dad_item_t  item_in,
  output logic                idle,
  output logic                done,
  output dad_pkg::dad_result_t result,
  input  logic                take
);
  import dad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] MODE_WALK   = 2'd0;
  localparam logic [1:0] MODE_BADM   = 2'd1;
  localparam logic [1:0] MODE_NONPOS = 2'd2;

  logic [2:0]            state;
  logic [1:0]            mode;
  dad_item_t             item;
  logic signed [OPW-1:0] nd;
  logic [MONTH_W-1:0]    nm;
  logic [WYEAR_W-1:0]    ny;
  logic [YEAR_W-1:0]     rem;
  logic [Y400_W-1:0]     y400;

  logic signed [OPW-1:0] op_a;
  logic signed [OPW-1:0] op_b;
  logic                  op_sub;
  dad_alu_res_t          alu_res;
  logic [DAY_W-1:0]      month_len;
  logic                  month_ok;
  logic                  year_low;

  assign month_len = days_of(nm, y400);
  assign month_ok  = (item_in.start_month >= JANUARY) && (item_in.start_month <= DECEMBER);
  assign year_low  = (ny < WYEAR_W'(MIN_YEAR));

  always_comb begin
    op_a   = nd;
    op_b   = OPW'(signed'({1'b0, month_len}));
    op_sub = 1'b1;
    unique case (state)
      S_ADD: begin
        op_a   = OPW'(signed'({1'b0, item.start_day}));
        op_b   = OPW'(item.days_away);
        op_sub = 1'b0;
      end
      S_MOD: begin
        op_a = OPW'(signed'({1'b0, rem}));
        op_b = LEAP_CYCLE;
      end
      default: begin
        op_a = nd;
      end
    endcase
  end

  dad_alu u_alu (
    .a   (op_a),
    .b   (op_b),
    .sub (op_sub),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item <= item_in;
            nm   <= item_in.start_month;
            ny   <= {1'b0, item_in.start_year};
            rem  <= item_in.start_year;
            if (month_ok) begin
              mode  <= MODE_WALK;
              state <= S_ADD;
            end else begin
              mode  <= MODE_BADM;
              state <= S_DONE;
            end
          end
        end
        S_ADD: begin
          nd <= alu_res.diff;
          if (alu_res.pos) begin
            state <= S_MOD;
          end else begin
            mode  <= MODE_NONPOS;
            state <= S_DONE;
          end
        end
        S_MOD: begin
          if (alu_res.neg) begin
            y400  <= rem[Y400_W-1:0];
            state <= S_WALK;
          end else begin
            rem <= alu_res.diff[YEAR_W-1:0];
          end
        end
        S_WALK: begin
          if (alu_res.pos) begin
            nd <= alu_res.diff;
            if (nm == DECEMBER) begin
              nm   <= JANUARY;
              ny   <= ny + WYEAR_W'(1);
              y400 <= (y400 == Y400_LAST) ? '0 : y400 + Y400_W'(1);
            end else begin
              nm <= nm + MONTH_W'(1);
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.result_month = nm;
    result.result_day   = item.start_day;
    result.result_year  = ny[YEAR_W-1:0];
    result.status       = year_low ? ST_LOW_YEAR : ST_BAD_MONTH;
    case (mode)
      MODE_NONPOS: begin
        result.result_day = '0;
        result.status     = year_low ? ST_LOW_YEAR : ST_BAD_DAY;
      end
      MODE_WALK: begin
        result.result_day = nd[DAY_W-1:0];
        if (ny > YEAR_MAX) begin
          result.result_year = YEAR_MAX[YEAR_W-1:0];
          result.status      = ST_OVERFLOW;
        end else begin
          result.status = year_low ? ST_LOW_YEAR : ST_OK;
        end
      end
      default: begin
        result.result_day = item.start_day;
      end
    endcase
  end

  // The walk only ever sees a real month and a positive day count.
  `DAD_ASSERT_NOW(a_walk_month, clk, rst, state == S_WALK, (nm >= JANUARY) && (nm <= DECEMBER))
  `DAD_ASSERT_NOW(a_walk_day_pos, clk, rst, state == S_WALK, !nd[OPW-1] && (nd != '0))
  `DAD_ASSERT_NEXT(a_done_holds, clk, rst, (state == S_DONE) && !take, state == S_DONE)
  `DAD_ASSERT_NOW(a_walk_ok_day, clk, rst,
                  (state == S_DONE) && (mode == MODE_WALK),
                  (nd != '0) && (nd <= OPW'(signed'({1'b0, DAY_W'(31)}))))

endmodule

// File: design/date_add_days.sv
// Top level of the date adder: stream ports, output register and the sequencer.
// Depends on dad_pkg and dad_ctrl.
//
//  Channel  Dir  Width  Carries
//  s_*      in   40     start_month, start_day, start_year, days_away
//  m_*      out  32     result_month, result_day, result_year, status
//
// A bad month sends an item straight to the result, and a day count that is not
// positive ends it after the offset add. Otherwise the year is reduced modulo 400 by
// repeated subtraction and the months are walked one per step; the single add/subtract
// unit, reused for every step, paces this. A new transfer is taken only when idle.
// rst is synchronous and empties the block. A result waits in the output register
// while the next transfer is taken; the sequencer holds only if that register is full.
`timescale 1ns / 1ps

module date_add_days #(
  parameter int unsigned MIN_YEAR = dad_pkg::MIN_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] start_month, [8:4] start_day, [22:9] start_year, [38:23] days_away, [39] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] result_month, [8:4] result_day, [22:9] result_year, [25:23] status, [31:26] zero
  output logic [31:0] m_tdata
);
  import dad_pkg::*;

  dad_item_t   item_in;
  dad_result_t result;
  dad_result_t out_reg;
  logic        idle;
  logic        done;
  logic        take;
  logic        start;

  assign item_in  = s_tdata[$bits(dad_item_t)-1:0];
  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign take     = done && (!m_tvalid || m_tready);

  dad_ctrl #(
    .MIN_YEAR (MIN_YEAR)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_in (item_in),
    .idle    (idle),
    .done    (done),
    .result  (result),
    .take    (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {(32 - $bits(dad_result_t))'(0), out_reg};

endmodule

// File: bench/date_add_days_tb.sv
// Self-checking bench for date_add_days: drives start dates and day offsets over the
// stream ports and checks every result against a typed expectation or a calendar predictor built in here.
// Depends on dad_pkg and the date_add_days RTL.
`timescale 1ns / 1ps

module date_add_days_tb;
  import dad_pkg::*;

  localparam int YEAR_TOP   = 16383;
  localparam int DRAIN_WAIT = 1200;
  localparam int LONG_HOLD  = 3000;
  localparam int PER_PHASE  = 160;

  typedef struct packed {
    logic        typed;
    dad_item_t   stim;
    dad_result_t want;
  } date_row_t;

  typedef struct packed {
    dad_item_t   stim;
    dad_result_t want;
  } date_pending_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  date_pending_t pending_q[$];
  date_row_t     dir_tab [24];
  int            mismatches;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_req;
  int            n_ok, n_low_year, n_bad_month, n_bad_day, n_overflow;

  date_add_days uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("Timeout with %0d results still outstanding", pending_q.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic bit leap_year(input int yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic int month_days(input int mon, input int yr);
    case (mon)
      2:           return leap_year(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Walks the day count forward month by month until it fits, as the block does.
  function automatic dad_result_t add_days_to_date(input dad_item_t stim);
    int          mon;
    int          day;
    int          yr;
    int          mlen;
    dad_result_t r;
    mon = stim.start_month;
    day = stim.start_day;
    yr  = stim.start_year;
    r.result_month = stim.start_month;
    r.result_day   = stim.start_day;
    r.result_year  = stim.start_year;
    if (mon < JANUARY || mon > DECEMBER) begin
      r.status = (yr < MIN_YEAR_DEF) ? ST_LOW_YEAR : ST_BAD_MONTH;
      return r;
    end
    day = day + $signed(stim.days_away);
    if (day <= 0) begin
      r.result_day = '0;
      r.status = (yr < MIN_YEAR_DEF) ? ST_LOW_YEAR : ST_BAD_DAY;
      return r;
    end
    mlen = month_days(mon, yr);
    while (day > mlen) begin
      day = day - mlen;
      mon = (mon % 12) + 1;
      if (mon == JANUARY) begin
        yr++;
      end
      mlen = month_days(mon, yr);
    end
    if (yr > YEAR_TOP) begin
      r.status = ST_OVERFLOW;
      yr = YEAR_TOP;
    end else if (yr < MIN_YEAR_DEF) begin
      r.status = ST_LOW_YEAR;
    end else begin
      r.status = ST_OK;
    end
    r.result_month = MONTH_W'(mon);
    r.result_day   = DAY_W'(day);
    r.result_year  = YEAR_W'(yr);
    return r;
  endfunction

  function automatic date_row_t date_row(input bit typed, input int m, input int d,
                                         input int y, input int off, input int em,
                                         input int ed, input int ey,
                                         input logic [STAT_W-1:0] est);
    date_row_t row;
    row.typed                  = typed;
    row.stim.start_month       = MONTH_W'(m);
    row.stim.start_day         = DAY_W'(d);
    row.stim.start_year        = YEAR_W'(y);
    row.stim.days_away         = OFF_W'(off);
    row.want.result_month      = MONTH_W'(em);
    row.want.result_day        = DAY_W'(ed);
    row.want.result_year       = YEAR_W'(ey);
    row.want.status            = est;
    return row;
  endfunction

  // Mostly nearby dates and short offsets, so that the month walk stays brief;
  // a tenth or so of the items span the whole offset range.
  function automatic dad_item_t random_date();
    dad_item_t stim;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      pick = $urandom_range(0, 3);
      stim.start_month = (pick == 0) ? '0 : MONTH_W'(12 + pick);
    end else begin
      stim.start_month = MONTH_W'($urandom_range(1, 12));
    end
    stim.start_day = DAY_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      stim.start_year = YEAR_W'($urandom_range(1850, 2150));
    end else if (pick < 80) begin
      stim.start_year = YEAR_W'($urandom_range(0, YEAR_TOP));
    end else if (pick < 90) begin
      stim.start_year = YEAR_W'($urandom_range(16300, YEAR_TOP));
    end else begin
      stim.start_year = YEAR_W'(400 * $urandom_range(0, 40) + $urandom_range(0, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      stim.days_away = OFF_W'(int'($urandom_range(0, 440)) - 40);
    end else if (pick < 87) begin
      stim.days_away = OFF_W'(int'($urandom_range(0, 6000)) - 3000);
    end else begin
      stim.days_away = OFF_W'($urandom);
    end
    return stim;
  endfunction

  task automatic send_date(input dad_item_t stim, input dad_result_t want);
    date_pending_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {8'($urandom), $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, stim};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p.stim = stim;
    p.want = want;
    pending_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input dad_item_t stim,
                                 input int want, input int got);
    mismatches++;
    $display("ERROR %0t: %s for %0d/%0d/%0d %0d days: expected %0d, got %0d", $time, what,
             stim.start_month, stim.start_day, stim.start_year, $signed(stim.days_away),
             want, got);
  endtask

  always @(posedge clk) begin : result_check
    dad_result_t   got;
    date_pending_t p;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(dad_result_t)-1:0];
      if (pending_q.size() == 0) begin
        report_mismatch("result with no transfer pending", '0, 0, int'(got));
      end else begin
        p = pending_q.pop_front();
        if (got.result_month !== p.want.result_month)
          report_mismatch("month", p.stim, p.want.result_month, got.result_month);
        if (got.result_day !== p.want.result_day)
          report_mismatch("day", p.stim, p.want.result_day, got.result_day);
        if (got.result_year !== p.want.result_year)
          report_mismatch("year", p.stim, p.want.result_year, got.result_year);
        if (got.status !== p.want.status)
          report_mismatch("status", p.stim, p.want.status, got.status);
        case (p.want.status)
          ST_OK:        n_ok++;
          ST_LOW_YEAR:  n_low_year++;
          ST_BAD_MONTH: n_bad_month++;
          ST_BAD_DAY:   n_bad_day++;
          default:      n_overflow++;
        endcase
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off once it is requested.
  initial begin
    int k;
    bit held;
    held     = 1'b0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0 && !held) begin
        m_tready <= 1'b0;
        for (k = 0; k < hold_req; k++) @(posedge clk);
        held = 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int        phase;
    int        i;
    dad_item_t stim;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    mismatches    = 0;
    hold_req      = 0;
    send_idle_pct = 22;
    recv_idle_pct = 50;
    n_ok = 0; n_low_year = 0; n_bad_month = 0; n_bad_day = 0; n_overflow = 0;

    // Rows marked 1 carry their result; the rest are left to the predictor.
    dir_tab[0]  = date_row(1, 0, 15, 2000, 5, 0, 15, 2000, ST_BAD_MONTH);
    dir_tab[1]  = date_row(1, 15, 31, 16383, -1, 15, 31, 16383, ST_BAD_MONTH);
    dir_tab[2]  = date_row(1, 13, 1, 1899, 0, 13, 1, 1899, ST_LOW_YEAR);
    dir_tab[3]  = date_row(1, 1, 0, 2000, 0, 1, 0, 2000, ST_BAD_DAY);
    dir_tab[4]  = date_row(1, 3, 1, 2020, -1, 3, 0, 2020, ST_BAD_DAY);
    dir_tab[5]  = date_row(1, 3, 1, 0, -32768, 3, 0, 0, ST_LOW_YEAR);
    dir_tab[6]  = date_row(1, 1, 1, 2000, 0, 1, 1, 2000, ST_OK);
    dir_tab[7]  = date_row(1, 2, 29, 2000, 0, 2, 29, 2000, ST_OK);
    dir_tab[8]  = date_row(0, 2, 29, 1900, 0, 0, 0, 0, ST_OK);
    dir_tab[9]  = date_row(1, 2, 29, 2024, 0, 2, 29, 2024, ST_OK);
    dir_tab[10] = date_row(0, 2, 29, 2100, 0, 0, 0, 0, ST_OK);
    dir_tab[11] = date_row(1, 12, 31, 1999, 1, 1, 1, 2000, ST_OK);
    dir_tab[12] = date_row(0, 4, 31, 2001, 0, 0, 0, 0, ST_OK);
    dir_tab[13] = date_row(0, 1, 31, 16383, 32767, 0, 0, 0, ST_OK);
    dir_tab[14] = date_row(1, 12, 31, 16383, 1, 1, 1, 16383, ST_OVERFLOW);
    dir_tab[15] = date_row(1, 1, 1, 1899, 10, 1, 11, 1899, ST_LOW_YEAR);
    dir_tab[16] = date_row(1, 12, 31, 1899, 1, 1, 1, 1900, ST_OK);
    dir_tab[17] = date_row(0, 6, 15, 2023, 32767, 0, 0, 0, ST_OK);
    dir_tab[18] = date_row(0, 1, 1, 0, 32767, 0, 0, 0, ST_OK);
    dir_tab[19] = date_row(1, 7, 31, 8191, -30, 7, 1, 8191, ST_OK);
    dir_tab[20] = date_row(0, 8, 1, 10922, 21845, 0, 0, 0, ST_OK);
    dir_tab[21] = date_row(1, 5, 10, 5461, -21846, 5, 0, 5461, ST_BAD_DAY);
    dir_tab[22] = date_row(1, 9, 31, 2000, -31, 9, 0, 2000, ST_BAD_DAY);
    dir_tab[23] = date_row(0, 11, 30, 1600, 365, 0, 0, 0, ST_OK);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 24; i++) begin
      send_date(dir_tab[i].stim,
                dir_tab[i].typed ? dir_tab[i].want : add_days_to_date(dir_tab[i].stim));
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 22; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 22; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // The sink stops for a long while so that the block backs up onto its input.
          hold_req = LONG_HOLD;
        end
      endcase
      repeat (PER_PHASE) begin
        stim = random_date();
        send_date(stim, add_days_to_date(stim));
      end
    end
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d dates: %0d valid, %0d before the minimum year, %0d bad month,",
             n_ok + n_low_year + n_bad_month + n_bad_day + n_overflow, n_ok, n_low_year,
             n_bad_month);
    $display("  %0d bad day and %0d past the top year, under three back-pressure mixes.",
             n_bad_day, n_overflow);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/dad_pkg.sv
design/dad_alu.sv
design/dad_ctrl.sv
design/date_add_days.sv
bench/date_add_days_tb.sv
